// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/pllr_pkg.sv =====
// Package with types and constants for the palette lattice lookup block.
package pllr_pkg;
    localparam logic [1:0] CMD_MAP = 2'd0;
    localparam logic [1:0] CMD_CELL = 2'd1;
    localparam logic [1:0] CMD_PAL = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [2:0] REG_REFINE = 3'd0;
    localparam logic [2:0] REG_DIST2 = 3'd1;
    localparam logic [2:0] REG_CACHE = 3'd2;
    localparam logic [2:0] REG_WX = 3'd3;
    localparam logic [2:0] REG_WY = 3'd4;
    localparam logic [2:0] REG_WZ = 3'd5;

    localparam logic [31:0] HASH_GOLD = 32'h9e3779b9;
    localparam logic [31:0] HASH_SEED = 32'h811c9dc5;

    // Lattice edge length; the 18-bit cell address holds exactly GRID cubed cells.
    localparam int GRID = 64;
    // Number of palette entries that can be written.
    localparam int PAL_ENTRIES = 256;

    // Queue entry between the front and the back.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [17:0] cell_addr;
        logic [7:0]  cell_color;
        logic        cell_edge;
        logic [25:0] cell_sqdist;
        logic [7:0]  color_slot;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sz;
    } t_item;

    // Register file contents handed to the back end.
    typedef struct packed {
        logic       refine_en;
        logic       dist2_en;
        logic       cache_en;
        logic [7:0] wx;
        logic [7:0] wy;
        logic [7:0] wz;
    } t_cfg;

    function automatic logic [31:0] mix32(input logic [31:0] acc, input logic [31:0] v);
        mix32 = acc ^ (v + HASH_GOLD + (acc << 6) + (acc >> 2));
    endfunction
endpackage

// ===== src/pllr_front.sv =====
// Front end: input register file of items and a short queue toward the back end.
module pllr_front
    import pllr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    // Four-entry queue; cmd 3 items are dropped here since they do nothing.
    t_item      r_mem [4];
    logic [2:0] r_wp, r_rp;
    logic [2:0] w_cnt;
    logic       w_push, w_pop;

    assign w_cnt   = r_wp - r_rp;
    assign o_ready = (w_cnt != 3'd4);
    assign w_push  = i_valid && o_ready && (i_item.cmd != CMD_NOP);
    assign o_valid = (w_cnt != 3'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rp[1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 3'd1;
            if (w_pop) r_rp <= r_rp + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp[1:0]] <= i_item;
    end
endmodule

// ===== src/pllr_back.sv =====
// Back end: quantizer, cache, lattice and palette memories, corner refinement.
module pllr_back
    import pllr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_data
);
    localparam int GB = $clog2(GRID);
    localparam int CB = 3 * GB;
    localparam int CELLS = GRID * GRID * GRID;
    localparam logic [GB-1:0] GMAX = GB'(GRID - 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_QUANT = 9'b000000010,
        S_LOOK  = 9'b000000100,
        S_CELL  = 9'b000001000,
        S_DEC   = 9'b000010000,
        S_CRD   = 9'b000100000,
        S_PRD   = 9'b001000000,
        S_ERR   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_st;
    t_item  r_it;

    // Memories, one port each.
    logic [34:0] r_cells [CELLS];
    logic [47:0] r_pal   [256];
    logic [34:0] r_cell_q;
    logic [47:0] r_pal_q;

    // Cache: 16 sets with the four ways packed per set; a way whose valid bit is
    // clear reads as an all-ones key holding -1.
    logic [127:0] r_key [16];
    logic [35:0]  r_val [16];
    logic [63:0]  r_vld;
    logic [1:0]   r_hand [16];

    logic [GB-1:0] r_qx, r_qy, r_qz;
    logic [31:0]   r_hkey;
    logic [8:0]    r_res;
    logic          r_hit, r_ref;
    logic [2:0]    r_corner;
    logic [7:0]    r_seen [8];
    logic [3:0]    r_nseen;
    logic [7:0]    r_cand;
    logic          r_dup;
    logic [41:0]   r_best;
    logic          r_have;
    logic [7:0]    r_bidx;
    logic [1:0]    r_ch;
    logic [41:0]   r_err;
    logic [31:0]   r_prod;
    logic [7:0]    r_wt;
    logic          r_out_v;
    logic [10:0]   r_out;

    // Quantizer: round(v*(G-1)*2+65535)/(131070). q = floor((v*(G-1)*2+65535)/131070).
    function automatic logic [GB-1:0] quant(input logic [15:0] v);
        logic [31:0] num;
        logic [GB:0] q;
        logic [63:0] t;
        num = 32'(v) * 32'(2 * (GRID - 1)) + 32'd65535;
        // Reciprocal estimate then one correction step.
        t = (64'(num) * 64'd2147516417) >> 48; // ~2^48/131070
        q = (GB+1)'(t);
        if (num >= 32'(q) * 32'd131070 + 32'd131070) q = q + 1'b1;
        if (q > (GB+1)'(GRID - 1)) q = (GB+1)'(GRID - 1);
        quant = q[GB-1:0];
    endfunction

    logic [CB-1:0] w_off;
    assign w_off = {r_qz, r_qy, r_qx};
    logic [3:0] w_set;
    assign w_set = r_hkey[3:0];

    // Corner address for the current corner index.
    logic [GB-1:0] w_cx, w_cy, w_cz;
    assign w_cx = (r_corner[0] && r_qx != GMAX) ? r_qx + 1'b1 : r_qx;
    assign w_cy = (r_corner[1] && r_qy != GMAX) ? r_qy + 1'b1 : r_qy;
    assign w_cz = (r_corner[2] && r_qz != GMAX) ? r_qz + 1'b1 : r_qz;

    logic [15:0] w_p, w_c;
    logic [7:0]  w_w;
    logic [15:0] w_d;
    always_comb begin
        case (r_ch)
            2'd0: begin w_p = r_it.sx; w_c = r_pal_q[15:0];  w_w = i_cfg.wx; end
            2'd1: begin w_p = r_it.sy; w_c = r_pal_q[31:16]; w_w = i_cfg.wy; end
            default: begin w_p = r_it.sz; w_c = r_pal_q[47:32]; w_w = i_cfg.wz; end
        endcase
        w_d = (w_p > w_c) ? w_p - w_c : w_c - w_p;
    end

    // Running error plus the weighted square of the previous channel.
    logic [41:0] w_sum;
    assign w_sum = r_err + 42'(r_prod) * 42'(r_wt);

    logic       w_hit;
    logic [8:0] w_hval;
    always_comb begin
        w_hit = 1'b0;
        w_hval = 9'h1FF;
        for (int k = 3; k >= 0; k--) begin
            if ((r_vld[{w_set, 2'(k)}] ? r_key[w_set][32*k +: 32] : 32'hFFFFFFFF)
                == r_hkey) begin
                w_hit = 1'b1;
                w_hval = r_vld[{w_set, 2'(k)}] ? r_val[w_set][9*k +: 9] : 9'h1FF;
            end
        end
    end

    logic w_dup;
    always_comb begin
        w_dup = 1'b0;
        for (int k = 0; k < 8; k++)
            if (4'(k) < r_nseen && r_seen[k] == r_cell_q[7:0]) w_dup = 1'b1;
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_out_v <= 1'b0;
            r_vld <= '0;
            for (int s = 0; s < 16; s++) r_hand[s] <= '0;
        end else begin
            if (r_out_v && i_ready && r_st != S_DONE) r_out_v <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_it <= i_item;
                    r_st <= S_QUANT;
                end
                S_QUANT: begin
                    if (r_it.cmd == CMD_CELL) begin
                        if (32'(r_it.cell_addr) < 32'(CELLS))
                            r_cells[r_it.cell_addr[CB-1:0]] <=
                                {r_it.cell_sqdist, r_it.cell_edge, r_it.cell_color};
                        r_vld <= '0;
                        for (int s = 0; s < 16; s++) r_hand[s] <= '0;
                        r_st <= S_IDLE;
                    end else if (r_it.cmd == CMD_PAL) begin
                        if (32'(r_it.color_slot) < 32'(PAL_ENTRIES))
                            r_pal[r_it.color_slot] <= {r_it.sz, r_it.sy, r_it.sx};
                        r_vld <= '0;
                        for (int s = 0; s < 16; s++) r_hand[s] <= '0;
                        r_st <= S_IDLE;
                    end else begin
                        r_qx <= quant(r_it.sx);
                        r_qy <= quant(r_it.sy);
                        r_qz <= quant(r_it.sz);
                        r_st <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hkey <= mix32(mix32(HASH_SEED, 32'(w_off)), 32'd0);
                    r_cell_q <= r_cells[w_off];
                    r_st <= S_CELL;
                end
                S_CELL: begin
                    r_hit <= i_cfg.cache_en && w_hit;
                    r_res <= (i_cfg.cache_en && w_hit) ? w_hval : {1'b0, r_cell_q[7:0]};
                    r_ref <= 1'b0;
                    r_st <= S_DEC;
                end
                S_DEC: begin
                    if (!r_hit && i_cfg.refine_en && r_cell_q[8] &&
                        (!i_cfg.dist2_en || ({r_cell_q[34:9], 2'b00} >
                         28'(i_cfg.wx) + 28'(i_cfg.wy) + 28'(i_cfg.wz)))) begin
                        r_ref <= 1'b1;
                        r_corner <= '0;
                        r_nseen <= '0;
                        r_have <= 1'b0;
                        r_st <= S_CRD;
                    end else begin
                        r_st <= S_DONE;
                    end
                end
                S_CRD: begin
                    r_cell_q <= r_cells[{w_cz, w_cy, w_cx}];
                    r_st <= S_PRD;
                end
                S_PRD: begin
                    r_dup <= w_dup;
                    r_cand <= r_cell_q[7:0];
                    if (!w_dup) begin
                        r_seen[r_nseen[2:0]] <= r_cell_q[7:0];
                        r_nseen <= r_nseen + 4'd1;
                    end
                    r_pal_q <= r_pal[r_cell_q[7:0]];
                    r_ch <= '0;
                    r_err <= '0;
                    r_prod <= '0;
                    r_wt <= '0;
                    r_st <= S_ERR;
                end
                S_ERR: begin
                    // One squared difference per cycle, weighted and accumulated in the next cycle.
                    if (r_dup || r_ch == 2'd3) begin
                        if (!r_dup && (!r_have || w_sum < r_best)) begin
                            r_best <= w_sum;
                            r_bidx <= r_cand;
                            r_have <= 1'b1;
                        end
                        if (r_corner == 3'd7) r_st <= S_DONE;
                        else begin
                            r_corner <= r_corner + 3'd1;
                            r_st <= S_CRD;
                        end
                    end else begin
                        r_prod <= 32'(w_d) * 32'(w_d);
                        r_wt <= w_w;
                        r_err <= w_sum;
                        r_ch <= r_ch + 2'd1;
                    end
                end
                S_DONE: if (!r_out_v || i_ready) begin
                    r_out_v <= 1'b1;
                    r_out <= {r_ref, r_hit, (r_ref ? {1'b0, r_bidx} : r_res)};
                    if (!r_hit && i_cfg.cache_en) begin
                        r_key[w_set][{r_hand[w_set], 5'd0} +: 32] <= r_hkey;
                        r_val[w_set][9 * int'(r_hand[w_set]) +: 9] <=
                            r_ref ? {1'b0, r_bidx} : r_res;
                        r_vld[{w_set, r_hand[w_set]}] <= 1'b1;
                        r_hand[w_set] <= r_hand[w_set] + 2'd1;
                    end
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/palette_lattice_lookup_refine.sv =====
// Top level of the palette lattice lookup block.
//  channel   dir  handshake            contents
//  s_axis    in   tvalid/tready        command word
//  m_axis    out  tvalid/tready        result word
//  apb       in   psel/penable/pready  six control registers
// A map word goes through the queue and back-end states IDLE, QUANT, LOOK, CELL, DEC, DONE.
// Refinement runs CRD, PRD and ERR per corner, all eight; a repeated color skips the sums.
// Table writes pass through IDLE and QUANT; the back end's single-port memories set the pace.
// Reset is synchronous and active low; the cache resets through valid bits.
// The input queue keeps accepting while the back end waits on m_axis_tready, until it is full.
module palette_lattice_lookup_refine
    import pllr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_addr, cell_color, cell_edge, cell_sqdist, color_slot, x, y, z
    input  logic [111:0] s_axis_tdata,
    // cmd
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // palette_index, cache_hit, refined
    output logic [15:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    t_cfg  r_cfg;
    t_item w_in, w_q;
    logic  w_qv, w_qr;
    logic [10:0] w_res;

    assign w_in = {s_axis_tuser, s_axis_tdata[17:0], s_axis_tdata[25:18],
                   s_axis_tdata[26], s_axis_tdata[52:27], s_axis_tdata[60:53],
                   s_axis_tdata[76:61], s_axis_tdata[92:77], s_axis_tdata[108:93]};
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{1'b0, 1'b0, 1'b0, 8'd1, 8'd1, 8'd1};
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_REFINE: r_cfg.refine_en <= pwdata[0];
                REG_DIST2:  r_cfg.dist2_en <= pwdata[0];
                REG_CACHE:  r_cfg.cache_en <= pwdata[0];
                REG_WX:     r_cfg.wx <= pwdata[7:0];
                REG_WY:     r_cfg.wy <= pwdata[7:0];
                REG_WZ:     r_cfg.wz <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_REFINE: prdata = 32'(r_cfg.refine_en);
            REG_DIST2:  prdata = 32'(r_cfg.dist2_en);
            REG_CACHE:  prdata = 32'(r_cfg.cache_en);
            REG_WX:     prdata = 32'(r_cfg.wx);
            REG_WY:     prdata = 32'(r_cfg.wy);
            REG_WZ:     prdata = 32'(r_cfg.wz);
            default:    prdata = '0;
        endcase
    end

    pllr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    pllr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_res)
    );

    assign m_axis_tdata = {5'd0, w_res};
endmodule

// ===== src/pllr_checker.sv =====
// Port-level checker for the palette lattice lookup block, with its bind.
`include "assert_macros.svh"
module pllr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        pready
);
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `ASSERT_IMP(a_hit_noref, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[9], !m_axis_tdata[10])
    `ASSERT_IMP(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[15:11] == 5'd0)
    `ASSERT_IMP(a_neg, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[9], !m_axis_tdata[8])
    `ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready)
endmodule

bind palette_lattice_lookup_refine pllr_checker u_chk (.*);

// ===== verif/palette_lookup_checker.sv =====
// Checker that predicts and compares the palette lookup results.
`timescale 1ns / 1ps
module palette_lookup_checker
    import pllr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [15:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_pending,
    output int           o_errors
);
    localparam int CELLS = GRID * GRID * GRID;

    typedef struct packed {
        logic signed [8:0] index;
        logic              hit;
        logic              refined;
    } t_lookup;

    logic [7:0]  cell_color [CELLS];
    logic        cell_edge [CELLS];
    logic [25:0] cell_dist [CELLS];
    logic [15:0] pal_color [256][3];
    logic [31:0] tag_store [64];
    logic signed [8:0] index_store [64];
    logic [1:0]  victim [16];
    t_cfg        cfg;
    t_lookup     expected_lookups[$];
    int          errors = 0;

    assign o_pending = expected_lookups.size();
    assign o_errors = errors;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void flush_cache();
        for (int i = 0; i < 64; i++) begin
            tag_store[i] = '1;
            index_store[i] = -9'sd1;
        end
        for (int i = 0; i < 16; i++) victim[i] = '0;
    endfunction

    function automatic logic [31:0] scramble(input logic [31:0] acc, input logic [31:0] v);
        return acc ^ ((acc >> 2) + (acc << 6) + 32'h9e3779b9 + v);
    endfunction

    function automatic int unsigned cell_coord(input logic [15:0] v);
        int unsigned q;
        q = (2 * (GRID - 1) * int'(v) + 65535) / 131070;
        return (q > GRID - 1) ? GRID - 1 : q;
    endfunction

    // Exhaustive search over the deduplicated corner colors; first strict minimum wins.
    function automatic logic signed [8:0] corner_search(input int unsigned x, y, z,
                                                        input logic [15:0] px [3]);
        int unsigned xs [2], ys [2], zs [2], seen [8];
        int unsigned nseen, cand, off;
        longint unsigned err, best_err, d, w;
        logic signed [8:0] best;
        bit dup;
        xs = '{x, (x + 1 >= GRID) ? GRID - 1 : x + 1};
        ys = '{y, (y + 1 >= GRID) ? GRID - 1 : y + 1};
        zs = '{z, (z + 1 >= GRID) ? GRID - 1 : z + 1};
        nseen = 0;
        best = -9'sd1;
        best_err = '1;
        for (int c = 0; c < 2; c++) begin
            for (int b = 0; b < 2; b++) begin
                for (int a = 0; a < 2; a++) begin
                    off = zs[c] * GRID * GRID + ys[b] * GRID + xs[a];
                    cand = cell_color[off];
                    dup = 0;
                    for (int k = 0; k < nseen; k++) if (seen[k] == cand) dup = 1;
                    if (!dup) begin
                        seen[nseen] = cand;
                        nseen++;
                        err = 0;
                        for (int ch = 0; ch < 3; ch++) begin
                            d = (px[ch] > pal_color[cand][ch]) ?
                                px[ch] - pal_color[cand][ch] : pal_color[cand][ch] - px[ch];
                            w = (ch == 0) ? cfg.wx : ((ch == 1) ? cfg.wy : cfg.wz);
                            err += w * d * d;
                        end
                        if (err < best_err) begin
                            best_err = err;
                            best = 9'(cand);
                        end
                    end
                end
            end
        end
        return best;
    endfunction

    // Applies one accepted command word to the shadow state and queues any result.
    function automatic void lattice_lookup(input logic [1:0] cmd, input logic [111:0] d);
        logic [15:0] px [3];
        int unsigned x, y, z, off, set, way;
        logic [31:0] key;
        t_lookup res;
        px = '{d[76:61], d[92:77], d[108:93]};
        if (cmd == CMD_CELL) begin
            cell_color[d[17:0]] = d[25:18];
            cell_edge[d[17:0]] = d[26];
            cell_dist[d[17:0]] = d[52:27];
            flush_cache();
        end else if (cmd == CMD_PAL) begin
            pal_color[d[60:53]] = px;
            flush_cache();
        end else if (cmd == CMD_MAP) begin
            x = cell_coord(px[0]);
            y = cell_coord(px[1]);
            z = cell_coord(px[2]);
            off = z * GRID * GRID + y * GRID + x;
            key = scramble(scramble(32'h811c9dc5, off), 32'd0);
            set = key[3:0];
            res = '{index: -9'sd1, hit: 1'b0, refined: 1'b0};
            if (cfg.cache_en) begin
                for (int w = 0; w < 4; w++) begin
                    if (!res.hit && tag_store[set * 4 + w] == key) begin
                        res.index = index_store[set * 4 + w];
                        res.hit = 1'b1;
                    end
                end
            end
            if (!res.hit) begin
                res.index = 9'(cell_color[off]);
                if (cfg.refine_en && cell_edge[off] &&
                    !(cfg.dist2_en &&
                      4 * longint'(cell_dist[off]) <= int'(cfg.wx) + cfg.wy + cfg.wz)) begin
                    res.index = corner_search(x, y, z, px);
                    res.refined = 1'b1;
                end
                if (cfg.cache_en) begin
                    way = victim[set];
                    tag_store[set * 4 + way] = key;
                    index_store[set * 4 + way] = res.index;
                    victim[set] = 2'(way + 1);
                end
            end
            expected_lookups.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            cfg <= '{refine_en: 1'b0, dist2_en: 1'b0, cache_en: 1'b0,
                     wx: 8'd1, wy: 8'd1, wz: 8'd1};
            flush_cache();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_REFINE: cfg.refine_en <= pwdata[0];
                    REG_DIST2:  cfg.dist2_en <= pwdata[0];
                    REG_CACHE:  cfg.cache_en <= pwdata[0];
                    REG_WX:     cfg.wx <= pwdata[7:0];
                    REG_WY:     cfg.wy <= pwdata[7:0];
                    REG_WZ:     cfg.wz <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) lattice_lookup(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
                end else begin
                    want = expected_lookups.pop_front();
                    if (m_axis_tdata[8:0] !== want.index)
                        report_mismatch($sformatf("palette_index %0d, expected %0d",
                                                  $signed(m_axis_tdata[8:0]), want.index));
                    if (m_axis_tdata[9] !== want.hit)
                        report_mismatch($sformatf("cache_hit %b, expected %b",
                                                  m_axis_tdata[9], want.hit));
                    if (m_axis_tdata[10] !== want.refined)
                        report_mismatch($sformatf("refined %b, expected %b",
                                                  m_axis_tdata[10], want.refined));
                end
            end
        end
    end
endmodule

// ===== verif/palette_lattice_lookup_refine_tb.sv =====
// Testbench top: stimulus, flow control and verdict for the palette lookup block.
`timescale 1ns / 1ps
module palette_lattice_lookup_refine_tb;
    import pllr_pkg::*;

    // Idle cycles without any accepted word before the run is declared hung.
    localparam int HANG_LIMIT = 20000;
    // Cycles to let a trailing table write drain before touching registers.
    localparam int DRAIN_CYCLES = 100;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // cell_addr, cell_color, cell_edge, cell_sqdist, color_slot, x, y, z
    logic [111:0] s_axis_tdata = '0;
    // cmd
    logic [1:0]   s_axis_tuser = CMD_MAP;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // palette_index, cache_hit, refined
    logic [15:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           pending;
    int           errors;
    int           idle_cycles = 0;
    bit           no_gaps = 1'b0;
    logic [47:0]  recent_pixels [8];

    // Lattice coordinates that are loaded into the table; map requests only use
    // the ones whose upper corner neighbor is loaded too, so no read ever touches
    // a cell that was never written.
    int unsigned loaded_coords [6] = '{0, 1, 31, 32, 62, 63};
    int unsigned map_coords [4] = '{0, 31, 62, 63};

    initial forever #2 i_clk = ~i_clk;

    palette_lattice_lookup_refine dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    palette_lookup_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_pending(pending), .o_errors(errors)
    );

    // The watchdog restarts whenever any word moves on either stream.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The result sink stalls a random number of cycles before each word,
    // except in phases that run without gaps.
    initial begin
        int n;
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [111:0] cell_word(input logic [17:0] addr, input logic [7:0] color,
                                               input logic edge_mark, input logic [25:0] sqdist);
        logic [111:0] w;
        w = 112'({$urandom, $urandom, $urandom, $urandom});
        w[17:0] = addr;
        w[25:18] = color;
        w[26] = edge_mark;
        w[52:27] = sqdist;
        return w;
    endfunction

    function automatic logic [111:0] sample_word(input logic [7:0] slot, input logic [47:0] xyz);
        logic [111:0] w;
        w = 112'({$urandom, $urandom, $urandom, $urandom});
        w[60:53] = slot;
        w[108:61] = xyz;
        w[111:109] = '0;
        return w;
    endfunction

    // A random channel value that quantizes to lattice coordinate q.
    function automatic logic [15:0] channel_for(input int unsigned q);
        int unsigned lo, hi;
        lo = (q == 0) ? 0 : ((2 * q - 1) * 65535 + 125) / 126;
        hi = (q == 63) ? 65535 : ((2 * q + 1) * 65535 + 125) / 126 - 1;
        return 16'($urandom_range(hi, lo));
    endfunction

    // Map pixels often repeat a recent one so that the cache sees hits.
    function automatic logic [47:0] map_pixel();
        logic [47:0] p;
        if ($urandom_range(0, 99) < 35) return recent_pixels[$urandom_range(0, 7)];
        p = {channel_for(map_coords[$urandom_range(0, 3)]),
             channel_for(map_coords[$urandom_range(0, 3)]),
             channel_for(map_coords[$urandom_range(0, 3)])};
        recent_pixels[$urandom_range(0, 7)] = p;
        return p;
    endfunction

    function automatic logic [17:0] loaded_cell();
        return 18'(loaded_coords[$urandom_range(0, 5)] * 4096 +
                   loaded_coords[$urandom_range(0, 5)] * 64 + loaded_coords[$urandom_range(0, 5)]);
    endfunction

    function automatic logic [25:0] cell_distance();
        case ($urandom_range(0, 3))
            0: return 26'($urandom);
            1: return '1;
            default: return 26'($urandom_range(0, 200));
        endcase
    endfunction

    // Presents one word; tvalid stays high across back-to-back words.
    task automatic send_word(input logic [1:0] cmd, input logic [111:0] data);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Registers only change once all results are back and trailing writes have drained.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input bit refine, dist2, cache, input logic [7:0] wx, wy, wz);
        write_reg(REG_REFINE, {31'd0, refine});
        write_reg(REG_DIST2, {31'd0, dist2});
        write_reg(REG_CACHE, {31'd0, cache});
        write_reg(REG_WX, {24'd0, wx});
        write_reg(REG_WY, {24'd0, wy});
        write_reg(REG_WZ, {24'd0, wz});
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            send_word(CMD_MAP, sample_word(8'($urandom), map_pixel()));
        end else if (pick < 86) begin
            send_word(CMD_CELL, cell_word(($urandom_range(0, 3) == 0) ? 18'($urandom) :
                                          loaded_cell(), 8'($urandom), 1'($urandom),
                                          cell_distance()));
        end else if (pick < 96) begin
            send_word(CMD_PAL, sample_word(8'($urandom), {$urandom, 16'($urandom)}));
        end else begin
            send_word(CMD_NOP, 112'({$urandom, $urandom, $urandom, $urandom}));
        end
    endtask

    initial begin
        logic [47:0] p;
        for (int i = 0; i < 8; i++) recent_pixels[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole palette and the loaded part of the lattice first.
        for (int s = 0; s < 256; s++) begin
            p = {$urandom, 16'($urandom)};
            if (s == 0) p = '0;
            if (s == 255) p = '1;
            send_word(CMD_PAL, sample_word(8'(s), p));
        end
        foreach (loaded_coords[z]) foreach (loaded_coords[y]) foreach (loaded_coords[x])
            send_word(CMD_CELL,
                      cell_word(18'(loaded_coords[z] * 4096 + loaded_coords[y] * 64 +
                                    loaded_coords[x]),
                                8'($urandom), 1'($urandom_range(0, 3) != 0), cell_distance()));

        // Directed: extreme pixels and table words under refinement with the cache on.
        settle();
        program_regs(1'b1, 1'b1, 1'b1, 8'd255, 8'd0, 8'd255);
        send_word(CMD_CELL, cell_word(18'h3FFFF, 8'hFF, 1'b1, '1));
        send_word(CMD_CELL, cell_word(18'h0, 8'h00, 1'b1, 26'd0));
        send_word(CMD_PAL, sample_word(8'hFF, '1));
        send_word(CMD_MAP, sample_word(8'h00, '0));
        send_word(CMD_MAP, sample_word(8'h00, '1));
        send_word(CMD_MAP, sample_word(8'h00, '1));
        send_word(CMD_MAP, sample_word(8'h00, '0));
        send_word(CMD_MAP, sample_word(8'h00, {16'hFFFF, 16'h0000, 16'hFFFF}));
        send_word(CMD_MAP, sample_word(8'h00, {16'h0000, 16'hFFFF, 16'h0000}));
        // Channel values right at the rounding step between coordinates 62 and 63.
        send_word(CMD_MAP, sample_word(8'h00, {16'd65015, 16'd65014, 16'd65015}));
        send_word(CMD_NOP, '1);
        send_word(CMD_MAP, sample_word(8'h00, {16'd65015, 16'd65014, 16'd65015}));
        // A cell write between two equal maps must make the second one miss.
        send_word(CMD_CELL, cell_word(18'd33, 8'h5A, 1'b0, 26'd1));
        send_word(CMD_MAP, sample_word(8'h00, {16'd65015, 16'd65014, 16'd65015}));
        // Ten more map words with random pixels, which often repeat a recent one.
        for (int i = 0; i < 10; i++) send_word(CMD_MAP, sample_word(8'h00, map_pixel()));

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 8; phase++) begin
            settle();
            no_gaps = (phase % 3 == 2);
            case (phase)
                0: program_regs(1'b0, 1'b0, 1'b0, 8'd1, 8'd1, 8'd1);
                1: program_regs(1'b1, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
                2: program_regs(1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255);
                3: program_regs(1'b1, 1'b1, 1'b1, 8'd1, 8'd1, 8'd1);
                default: program_regs(1'($urandom), 1'($urandom), 1'($urandom),
                                      8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            for (int i = 0; i < 145; i++) random_word();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
